// File: rtl/fmpt_pkg.sv
// Package for the flow meter pulse totaliser.
// Holds the job word passed from the front to the back, register codes and
// the fixed arithmetic constants. No dependencies.
package fmpt_pkg;

  // Configuration register codes.
  localparam logic [1:0] REG_LOCKOUT = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_PPL     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [9:0]  LOCKOUT_RST = 10'd50;
  localparam logic [15:0] WINDOW_RST  = 16'd1000;
  localparam logic [15:0] PPL_RST     = 16'd75;

  // Arithmetic widths and scale factors.
  localparam int unsigned RATE_NUM_W = 42;
  localparam int unsigned RATE_DEN_W = 32;
  localparam int unsigned VOL_NUM_W  = 58;
  localparam int unsigned VOL_DEN_W  = 16;

  localparam logic [25:0] RATE_SCALE = 26'd60000000;
  localparam logic [25:0] RATE_MAX   = 26'd60000000;
  localparam logic [9:0]  VOL_SCALE  = 10'd1000;

  // One closed window, as handed from the front to the back.
  typedef struct packed {
    logic [15:0] pulses;
    logic [15:0] elapsed;
    logic [47:0] total;
    logic [15:0] ppl;
  } fmpt_job_t;

endpackage

// File: rtl/fmpt_front.sv
// Front end of the flow meter pulse totaliser: configuration registers,
// debounce lockout, window timing and the running total.
// Depends on fmpt_pkg.
module fmpt_front import fmpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        tick_valid_i,
  output logic        tick_ready_o,
  input  logic        pulse_edge_i,
  input  logic        queue_full_i,
  output logic        job_push_o,
  output fmpt_job_t   job_o
);

  logic [9:0]  lockout_q;
  logic [15:0] window_q;
  logic [15:0] ppl_q;
  logic [10:0] since_q,   since_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] pulses_q,  pulses_d;
  logic [47:0] total_q,   total_d;
  logic [15:0] win_eff;
  logic [48:0] total_sum;
  logic        counted;
  logic        closing;
  logic        accept;

  assign tick_ready_o = !queue_full_i;
  assign accept       = tick_valid_i && tick_ready_o;
  assign win_eff      = (window_q == 16'd0) ? 16'd1 : window_q;

  always_comb begin
    since_d   = (since_q != '1) ? since_q + 11'd1 : since_q;
    counted   = pulse_edge_i && (since_d > {1'b0, lockout_q});
    pulses_d  = pulses_q;
    if (counted) begin
      since_d = '0;
      if (pulses_q != '1) begin
        pulses_d = pulses_q + 16'd1;
      end
    end
    elapsed_d = (elapsed_q != '1) ? elapsed_q + 16'd1 : elapsed_q;
    closing   = elapsed_d >= win_eff;
    total_sum = {1'b0, total_q} + {33'd0, pulses_d};
    total_d   = total_sum[48] ? '1 : total_sum[47:0];
  end

  assign job_push_o     = accept && closing;
  assign job_o.pulses   = pulses_d;
  assign job_o.elapsed  = elapsed_d;
  assign job_o.total    = total_d;
  assign job_o.ppl      = (ppl_q == 16'd0) ? 16'd1 : ppl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LOCKOUT_RST;
      window_q  <= WINDOW_RST;
      ppl_q     <= PPL_RST;
      since_q   <= '0;
      elapsed_q <= '0;
      pulses_q  <= '0;
      total_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_LOCKOUT: lockout_q <= cfg_data_i[9:0];
          REG_WINDOW:  window_q  <= cfg_data_i;
          REG_PPL:     ppl_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        since_q <= since_d;
        if (closing) begin
          elapsed_q <= '0;
          pulses_q  <= '0;
          total_q   <= total_d;
        end else begin
          elapsed_q <= elapsed_d;
          pulses_q  <= pulses_d;
        end
      end
    end
  end

endmodule

// File: rtl/fmpt_queue.sv
// Short job queue between the front and the back of the totaliser.
// Depends on fmpt_pkg for the job word.
module fmpt_queue import fmpt_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fmpt_job_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      pop_valid_o,
  output fmpt_job_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  fmpt_job_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_pop;

  assign full_o      = count_q == CNT_W'(DEPTH);
  assign pop_valid_o = count_q != '0;
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || do_pop))
    else $error("job queue written while full");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("job queue count beyond depth");
`endif

endmodule

// File: rtl/fmpt_div.sv
// Restoring divider for the totaliser, one quotient bit per cycle.
// No package dependencies.
module fmpt_div #(
  parameter int unsigned NUM_W = 42,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !diff[DEN_W+1];
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");
`endif

endmodule

// File: rtl/fmpt_back.sv
// Back end of the totaliser: turns a closed window into rate and volume
// with two dividers and holds the result word. Depends on fmpt_pkg, fmpt_div.
module fmpt_back import fmpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_pop_o,
  input  fmpt_job_t   job_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [15:0] res_pulses_o,
  output logic [25:0] res_rate_o,
  output logic [31:0] res_volume_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                 state_q;
  fmpt_job_t              job_q;
  logic [RATE_NUM_W-1:0]  rate_num_q;
  logic [RATE_DEN_W-1:0]  rate_den_q;
  logic [VOL_NUM_W-1:0]   vol_num_q;
  logic                   start_q;
  logic                   rate_done_q;
  logic                   vol_done_q;
  logic                   rate_done;
  logic                   vol_done;
  logic [RATE_NUM_W-1:0]  rate_quot;
  logic [VOL_NUM_W-1:0]   vol_quot;
  logic                   res_valid_q;
  logic [15:0]            res_pulses_q;
  logic [25:0]            res_rate_q;
  logic [31:0]            res_volume_q;
  logic [25:0]            rate_sat;
  logic [31:0]            vol_sat;

  assign job_pop_o = (state_q == ST_IDLE);

  fmpt_div #(.NUM_W(RATE_NUM_W), .DEN_W(RATE_DEN_W)) u_rate_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .num_i  (rate_num_q),
    .den_i  (rate_den_q),
    .done_o (rate_done),
    .quot_o (rate_quot)
  );

  fmpt_div #(.NUM_W(VOL_NUM_W), .DEN_W(VOL_DEN_W)) u_vol_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .num_i  (vol_num_q),
    .den_i  (job_q.ppl),
    .done_o (vol_done),
    .quot_o (vol_quot)
  );

  assign rate_sat = (rate_quot > {16'd0, RATE_MAX}) ? RATE_MAX : rate_quot[25:0];
  assign vol_sat  = (vol_quot[VOL_NUM_W-1:32] != '0) ? '1 : vol_quot[31:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      job_q <= job_i;
    end
    if (state_q == ST_MUL) begin
      rate_num_q <= RATE_NUM_W'(job_q.pulses) * RATE_NUM_W'(RATE_SCALE);
      rate_den_q <= RATE_DEN_W'(job_q.ppl) * RATE_DEN_W'(job_q.elapsed);
      vol_num_q  <= VOL_NUM_W'(job_q.total) * VOL_NUM_W'(VOL_SCALE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      start_q      <= 1'b0;
      rate_done_q  <= 1'b0;
      vol_done_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      res_pulses_q <= '0;
      res_rate_q   <= '0;
      res_volume_q <= '0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          start_q     <= 1'b1;
          rate_done_q <= 1'b0;
          vol_done_q  <= 1'b0;
          state_q     <= ST_DIV;
        end
        ST_DIV: begin
          rate_done_q <= rate_done_q || rate_done;
          vol_done_q  <= vol_done_q || vol_done;
          if ((rate_done_q || rate_done) && (vol_done_q || vol_done)) begin
            res_valid_q  <= 1'b1;
            res_pulses_q <= job_q.pulses;
            res_rate_q   <= rate_sat;
            res_volume_q <= vol_sat;
            state_q      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res_ready_i) begin
            res_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_pulses_o = res_pulses_q;
  assign res_rate_o   = res_rate_q;
  assign res_volume_o = res_volume_q;

`ifndef ASSERT_OFF
  a_rate_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_rate_q <= RATE_MAX))
    else $error("flow rate above its saturation bound");
  a_valid_only_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == ST_OUT))
    else $error("result shown outside the output state");
`endif

endmodule

// File: rtl/flow_meter_pulse_totalizer.sv
// Top level of the flow meter pulse totaliser: front end, job queue and
// divider back end. Depends on fmpt_pkg, fmpt_front, fmpt_queue, fmpt_back.
//
//   Channel   Direction  Word
//   s_axis    in         one millisecond tick: tdata[0] pulse_edge
//   m_axis    out        one closed window: pulses, rate, volume
//   cfg       in         register write: index 0 lockout, 1 window, 2 ppl
//
// A tick is taken whenever the job queue has room, so ticks may arrive back
// to back. A tick that closes a window leaves a job in the queue; the back
// end takes one job at a time, and the 58-step volume divider running beside
// the 42-step rate divider sets its pace. Reset clears all counters, the
// queue and the output, and loads the default configuration. A stalled
// output holds the back end, then fills the queue, then stalls ticks.
module flow_meter_pulse_totalizer import fmpt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pulse_edge, [7:1] ignored
  // Window results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [15:0] window_pulse_count,
                                      // [41:16] flow_rate_centi_lpm,
                                      // [73:42] total_volume_cl, [79:74] zero
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  fmpt_job_t   push_job;
  fmpt_job_t   pop_job;
  logic        push;
  logic        full;
  logic        pop;
  logic        pop_valid;
  logic [15:0] res_pulses;
  logic [25:0] res_rate;
  logic [31:0] res_volume;

  // Registers are always writable; the user must write them only while idle, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  // The front end debounces edges, times the window and keeps the total.
  fmpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_valid_i(s_axis_tvalid),
    .tick_ready_o(s_axis_tready),
    .pulse_edge_i(s_axis_tdata[0]),
    .queue_full_i(full),
    .job_push_o  (push),
    .job_o       (push_job)
  );

  // The queue lets ticks flow on while the dividers work on a closed window.
  fmpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (full),
    .pop_i      (pop),
    .pop_valid_o(pop_valid),
    .pop_data_o (pop_job)
  );

  // The back end derives rate and volume and holds the result word.
  fmpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_pop_o   (pop),
    .job_i       (pop_job),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_pulses_o(res_pulses),
    .res_rate_o  (res_rate),
    .res_volume_o(res_volume)
  );

  assign m_axis_tdata = {6'd0, res_volume, res_rate, res_pulses};

endmodule

// File: tb/sv/flow_meter_pulse_totalizer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the flow meter pulse totaliser. It watches the tick, result
// and register-write channels, predicts each closed window and compares it.
// Depends on fmpt_pkg for the register codes, reset values and scale factors.
module flow_meter_pulse_totalizer_checker import fmpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_valid_i,
  input  logic        tick_ready_i,
  input  logic [7:0]  tick_data_i,     // [0] pulse_edge, [7:1] ignored
  input  logic        result_valid_i,
  input  logic        result_ready_i,
  input  logic [79:0] result_data_i,   // [15:0] pulses, [41:16] rate,
                                       // [73:42] volume, [79:74] zero
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [10:0] SINCE_SAT   = 11'h7FF;
  localparam logic [15:0] COUNT_SAT   = 16'hFFFF;
  localparam logic [47:0] TOTAL_SAT   = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] VOLUME_SAT  = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] pulses;
    logic [25:0] rate;
    logic [31:0] volume;
  } window_result_t;

  logic [9:0]  lockout_ms   = LOCKOUT_RST;
  logic [15:0] window_ms    = WINDOW_RST;
  logic [15:0] ppl_tenths   = PPL_RST;
  logic [10:0] since_ms     = '0;
  logic [15:0] elapsed_ms   = '0;
  logic [15:0] win_pulses   = '0;
  logic [47:0] total_pulses = '0;

  window_result_t expected_windows_q[$];
  int unsigned    fail_count = 0;

  // Advances the meter by one millisecond tick and queues the window it closes.
  task automatic count_tick(input logic pulse_bit);
    logic [15:0]    win_len;
    logic [63:0]    ppl;
    logic [63:0]    total_sum;
    logic [63:0]    rate;
    logic [63:0]    volume;
    window_result_t res;
    win_len = (window_ms == '0) ? 16'd1 : window_ms;
    ppl     = (ppl_tenths == '0) ? 64'd1 : 64'(ppl_tenths);
    if (since_ms != SINCE_SAT) since_ms = since_ms + 11'd1;
    if (pulse_bit && since_ms > {1'b0, lockout_ms}) begin
      if (win_pulses != COUNT_SAT) win_pulses = win_pulses + 16'd1;
      since_ms = '0;
    end
    if (elapsed_ms != COUNT_SAT) elapsed_ms = elapsed_ms + 16'd1;
    if (elapsed_ms >= win_len) begin
      total_sum    = 64'(total_pulses) + 64'(win_pulses);
      total_pulses = (total_sum > 64'(TOTAL_SAT)) ? TOTAL_SAT : total_sum[47:0];
      rate = (64'(win_pulses) * 64'(RATE_SCALE)) / (ppl * 64'(elapsed_ms));
      if (rate > 64'(RATE_MAX)) rate = 64'(RATE_MAX);
      volume = (64'(total_pulses) * 64'(VOL_SCALE)) / ppl;
      if (volume > VOLUME_SAT) volume = VOLUME_SAT;
      res.pulses = win_pulses;
      res.rate   = rate[25:0];
      res.volume = volume[31:0];
      expected_windows_q.push_back(res);
      elapsed_ms = '0;
      win_pulses = '0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  task automatic check_result(input logic [79:0] word);
    window_result_t exp_res;
    if (expected_windows_q.size() == 0) begin
      fail_count++;
      $display("%0t: result expected none actual %h", $time, word);
    end else begin
      exp_res = expected_windows_q.pop_front();
      compare_field("window_pulse_count", 32'(exp_res.pulses), 32'(word[15:0]));
      compare_field("flow_rate_centi_lpm", 32'(exp_res.rate), 32'(word[41:16]));
      compare_field("total_volume_cl", exp_res.volume, word[73:42]);
      compare_field("padding", 32'd0, 32'(word[79:74]));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ms   = LOCKOUT_RST;
      window_ms    = WINDOW_RST;
      ppl_tenths   = PPL_RST;
      since_ms     = '0;
      elapsed_ms   = '0;
      win_pulses   = '0;
      total_pulses = '0;
      expected_windows_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LOCKOUT: lockout_ms = cfg_data_i[9:0];
          REG_WINDOW:  window_ms  = cfg_data_i;
          REG_PPL:     ppl_tenths = cfg_data_i;
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) count_tick(tick_data_i[0]);
      if (result_valid_i && result_ready_i) check_result(result_data_i);
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_windows_q.size();
  end

endmodule

// File: tb/sv/flow_meter_pulse_totalizer_tb.sv
`timescale 1ns / 1ps
// Testbench top for flow_meter_pulse_totalizer: makes ticks, register writes
// and output back-pressure, and gives the verdict. Depends on fmpt_pkg, the
// block itself and flow_meter_pulse_totalizer_checker.
module flow_meter_pulse_totalizer_tb;
  import fmpt_pkg::*;

  // Index 3 is not a register; a write to it must change nothing.
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam int unsigned RESET_CYCLES = 6;
  // Extra wait once no expected word is pending, so this covers a job that
  // is still in flight when the last expected word has been seen.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned LONG_STALL   = 400;
  localparam int unsigned RANDOM_TICKS = 1150;
  localparam int unsigned WIDE_WINDOW  = 200;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;     // [0] pulse_edge, [7:1] ignored
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;           // [15:0] pulses, [41:16] rate,
                                       // [73:42] volume, [79:74] zero
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count  = 0;
  int unsigned random_ticks = 0;
  // Raised by the stimulus, cleared by the receiver once it starts its stall.
  logic        stall_req    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  flow_meter_pulse_totalizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  flow_meter_pulse_totalizer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_valid_i   (s_axis_tvalid),
    .tick_ready_i   (s_axis_tready),
    .tick_data_i    (s_axis_tdata),
    .result_valid_i (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_data_i  (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Gap lengths: mostly none, often short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One register write. Valid stays high between writes of a group, so it is
  // only lowered after the last word of the group has been taken.
  task automatic write_reg(input logic [1:0] index, input logic [15:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  // Offers one tick word until it is taken, then idles for the given gap.
  // With no gap, valid stays high for the next word.
  task automatic send_tick(input logic [7:0] word, input int unsigned gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // A run of ticks with edges at the given percentage. Now and then the
  // unused upper bits are set, which the block must ignore. The last tick
  // always has a gap so that valid is low when the run ends.
  task automatic run_ticks(input int unsigned n, input int unsigned edge_pct,
                           input bit gaps_on);
    logic [7:0]  word;
    int unsigned gap;
    for (int unsigned i = 0; i < n; i++) begin
      word = {7'd0, ($urandom_range(0, 99) < edge_pct)};
      if ($urandom_range(0, 7) == 0) word[7:1] = 7'($urandom);
      gap = gaps_on ? pick_gap() : 0;
      if (i == n - 1 && gap == 0) gap = 1;
      send_tick(word, gap);
    end
  endtask

  // Waits until every expected window has come out and the back end has had
  // time to finish any job that is still working. Registers may then change.
  task automatic settle();
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // A random setting of all three registers, extremes included. Lockout
  // sometimes carries junk above bit 9, and the unused index is hit at times.
  task automatic random_config();
    logic [15:0] lockout;
    logic [15:0] window;
    logic [15:0] ppl;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30)      lockout = 16'd0;
    else if (roll < 70) lockout = 16'($urandom_range(1, 6));
    else if (roll < 85) lockout = 16'($urandom_range(7, 60));
    else if (roll < 92) lockout = 16'd1000;
    else                lockout = 16'($urandom_range(0, 1023));
    if ($urandom_range(0, 7) == 0) lockout[15:10] = 6'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 5)       window = 16'd0;
    else if (roll < 45) window = 16'($urandom_range(1, 8));
    else if (roll < 83) window = 16'($urandom_range(9, 40));
    else if (roll < 96) window = 16'($urandom_range(41, 300));
    else if (roll < 98) window = 16'd60000;
    else                window = 16'hFFFF;
    roll = $urandom_range(0, 99);
    if (roll < 5)       ppl = 16'd0;
    else if (roll < 15) ppl = 16'd1;
    else if (roll < 30) ppl = PPL_RST;
    else if (roll < 40) ppl = 16'hFFFF;
    else if (roll < 70) ppl = 16'($urandom_range(1, 200));
    else                ppl = 16'($urandom);
    write_reg(REG_WINDOW, window, 1'b0);
    if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, 16'($urandom), 1'b0);
    write_reg(REG_LOCKOUT, lockout, 1'b0);
    write_reg(REG_PPL, ppl, 1'b1);
  endtask

  // Receiver: bursts of ready broken by random holds, plus one long stall on
  // request that is counted here while the sender keeps offering ticks.
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    hold_left = 0;
    run_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = LONG_STALL;
        run_left  = 0;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) begin
          m_axis_tready <= 1'b1;
          run_left = $urandom_range(1, 24);
        end
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        hold_left = pick_gap();
        if (hold_left != 0) begin
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          run_left = $urandom_range(1, 24);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned edge_pct;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero window and zero calibration both behave as one, and with no
    // lockout every edge counts: each tick closes its own window. Junk in
    // the upper tick bits must not turn a quiet tick into an edge.
    write_reg(REG_WINDOW, 16'd0, 1'b0);
    write_reg(REG_LOCKOUT, 16'd0, 1'b0);
    write_reg(REG_PPL, 16'd0, 1'b1);
    send_tick(8'h01, 0);
    send_tick(8'h01, 0);
    send_tick(8'h00, 1);
    send_tick(8'hFF, 2);
    send_tick(8'hFE, 1);
    settle();

    // Short lockout against a solid run of edges, largest calibration.
    write_reg(REG_LOCKOUT, 16'd3, 1'b0);
    write_reg(REG_WINDOW, 16'd8, 1'b0);
    write_reg(REG_PPL, 16'hFFFF, 1'b1);
    run_ticks(8, 100, 1'b0);
    settle();

    // A write to the unused index, then a lockout word with every bit set
    // (only the low ten bits count). The window is then cut short below the
    // ticks already elapsed, so it closes on the next tick over five ticks.
    write_reg(REG_UNUSED, 16'hFFFF, 1'b0);
    write_reg(REG_LOCKOUT, 16'hFFFF, 1'b0);
    write_reg(REG_WINDOW, 16'd10, 1'b1);
    run_ticks(4, 100, 1'b0);
    settle();
    write_reg(REG_WINDOW, 16'd2, 1'b1);
    send_tick(8'h01, 1);
    settle();

    // Full rate: a tenth of a pulse per liter and an edge every tick gives
    // the top of the rate range. The receiver stalls for a long stretch here so
    // the queue fills and the block has to refuse ticks.
    write_reg(REG_LOCKOUT, 16'd0, 1'b0);
    write_reg(REG_WINDOW, 16'd1, 1'b0);
    write_reg(REG_PPL, 16'd1, 1'b1);
    stall_req = 1'b1;
    run_ticks(40, 100, 1'b0);

    // Random phases. A window may be left open when the settings change,
    // which is how shortened windows keep turning up.
    while (random_ticks < RANDOM_TICKS) begin
      settle();
      random_config();
      n = $urandom_range(15, 60);
      case ($urandom_range(0, 3))
        0:       edge_pct = 5;
        1:       edge_pct = 30;
        2:       edge_pct = 70;
        default: edge_pct = 100;
      endcase
      run_ticks(n, edge_pct, ($urandom_range(0, 3) != 0));
      random_ticks += n;
    end
    settle();

    // A long window filled with counted edges and the largest calibration
    // gives a wide rate divisor.
    write_reg(REG_LOCKOUT, 16'd0, 1'b0);
    write_reg(REG_WINDOW, 16'(WIDE_WINDOW), 1'b0);
    write_reg(REG_PPL, 16'hFFFF, 1'b1);
    run_ticks(WIDE_WINDOW, 100, 1'b0);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
